/* design/sam_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shift-and matcher package
// Shared constants, command codes and the control bundle broadcast to the
// row of matcher cells.
// ----------------------------------------------------------------------------
package sam_pkg;

   localparam int MAX_PATTERN = 256;
   localparam int STORE_DEPTH = 256;
   localparam int NUM_CELLS   = (MAX_PATTERN < STORE_DEPTH) ? MAX_PATTERN : STORE_DEPTH;
   localparam int VEC_IDX_W   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

   localparam int CMD_W   = 2;
   localparam int INDEX_W = 8;
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 9;
   localparam int POS_W   = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD    = 2'd0,
      CMD_TEXT    = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

   typedef struct packed {
      logic               load;
      logic               text;
      logic               clear;
      logic [INDEX_W-1:0] index;
      logic [BYTE_W-1:0]  value;
   } cell_ctrl_type;

endpackage
`default_nettype wire

/* design/sam_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shift-and matcher cell
// Holds one pattern byte and one match-vector bit, which a restart clears.
// On each text transfer it takes its neighbor's bit, kept if its byte matches.
// ----------------------------------------------------------------------------
module sam_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sam_pkg::cell_ctrl_type        ctrl,
   input  wire logic [sam_pkg::INDEX_W-1:0]   cell_index,
   input  wire logic                          prev_match,
   output logic                               match_out
);

   logic [sam_pkg::BYTE_W-1:0] pattern_ff;
   logic                       match_bit_ff;
   logic                       match_bit_in;

   always_comb begin
      match_bit_in = match_bit_ff;
      if (ctrl.clear) begin
         match_bit_in = 1'b0;
      end else if (ctrl.text) begin
         match_bit_in = prev_match & (pattern_ff == ctrl.value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_bit_ff <= 1'b0;
      end else begin
         match_bit_ff <= match_bit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load && (ctrl.index == cell_index)) begin
         pattern_ff <= ctrl.value;
      end
   end

   assign match_out = match_bit_ff;

endmodule
`default_nettype wire

/* design/shift_and_exact_matcher.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shift-and exact matcher
// Bitap exact string matcher built as a row of byte cells.
// ----------------------------------------------------------------------------
// Pattern bytes are loaded by index, then text bytes stream in one per
// transfer, and every transfer of any command returns exactly one result.
// The block takes one transfer per cycle unless the result stage stalls:
// each cell updates its match bit in the cycle the byte is taken, and the
// result stage registers the selected vector bit and the start position.
// A stalled result stage holds the cell row still once one further
// transfer has been taken while a result waits. There is no clearing pass
// after reset, since pattern bytes are valid only once loaded. The pattern
// length register must be written only while no transfer is in flight.
// ----------------------------------------------------------------------------
module shift_and_exact_matcher (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [sam_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [sam_pkg::INDEX_W-1:0]   req_pattern_index,
   input  wire logic [sam_pkg::BYTE_W-1:0]    req_byte_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_match,
   output logic [sam_pkg::POS_W-1:0]          rsp_start_position,
   input  wire logic                          csr_write_enable,
   input  wire logic [sam_pkg::LEN_W-1:0]     csr_write_data
);

   localparam int N = sam_pkg::NUM_CELLS;

   logic [sam_pkg::LEN_W-1:0] length_ff;
   logic [sam_pkg::POS_W-1:0] position_ff;
   logic [sam_pkg::POS_W-1:0] position_in;

   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   logic                      s1_text_ff;
   logic [sam_pkg::POS_W-1:0] s1_pos_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      rsp_match_ff;
   logic                      rsp_match_in;
   logic [sam_pkg::POS_W-1:0] rsp_start_ff;
   logic [sam_pkg::POS_W-1:0] rsp_start_in;

   logic                      advance;
   logic                      accept;
   sam_pkg::cell_ctrl_type    ctrl;
   logic [N-1:0]              vec;
   logic [N-1:0]              prev_vec;

   logic [sam_pkg::LEN_W-1:0]     len_eff;
   logic [sam_pkg::LEN_W-1:0]     len_m1;
   logic [sam_pkg::VEC_IDX_W-1:0] sel;
   logic                          hit;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      ctrl       = '0;
      ctrl.index = req_pattern_index;
      ctrl.value = req_byte_value;
      unique case (sam_pkg::cmd_type'(req_cmd))
         sam_pkg::CMD_LOAD: begin
            ctrl.load = accept;
         end
         sam_pkg::CMD_TEXT: begin
            ctrl.text = accept;
         end
         sam_pkg::CMD_RESTART: begin
            ctrl.clear = accept;
         end
         default: begin
            ctrl.load = 1'b0;
         end
      endcase
   end

   for (genvar g = 0; g < N; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign prev_vec[g] = 1'b1;
      end else begin : g_rest
         assign prev_vec[g] = vec[g-1];
      end
      sam_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .cell_index (sam_pkg::INDEX_W'(g)),
         .prev_match (prev_vec[g]),
         .match_out  (vec[g])
      );
   end

   always_comb begin
      position_in = position_ff;
      if (ctrl.clear) begin
         position_in = '0;
      end else if (ctrl.text && (position_ff != '1)) begin
         position_in = position_ff + 1'b1;
      end
   end

   always_comb begin
      len_eff = (length_ff > sam_pkg::LEN_W'(N)) ? sam_pkg::LEN_W'(N) : length_ff;
      len_m1  = len_eff - 1'b1;
      sel     = len_m1[sam_pkg::VEC_IDX_W-1:0];
      hit     = s1_text_ff && (len_eff != '0)
                && (s1_pos_ff >= sam_pkg::POS_W'(len_m1)) && vec[sel];
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_match_in = rsp_match_ff;
      rsp_start_in = rsp_start_ff;
      if (advance) begin
         s1_valid_in  = accept;
         rsp_valid_in = s1_valid_ff;
         rsp_match_in = hit;
         rsp_start_in = hit ? (s1_pos_ff - sam_pkg::POS_W'(len_m1)) : '0;
      end else if (accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= sam_pkg::LEN_W'(1);
         position_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            length_ff <= csr_write_data;
         end
         position_ff  <= position_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_text_ff <= ctrl.text;
         s1_pos_ff  <= position_ff;
      end
      rsp_match_ff <= rsp_match_in;
      rsp_start_ff <= rsp_start_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_match          = rsp_match_ff;
   assign rsp_start_position = rsp_start_ff;

endmodule
`default_nettype wire

/* design/sam_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shift-and matcher checker
// Port-level checks of the matcher, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sam_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_match,
   input wire logic [sam_pkg::POS_W-1:0]     rsp_start_position
);

   // A result that is not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match)
                                  && $stable(rsp_start_position))
      else $error("result changed while stalled");

   // A result without a match carries a zero start position.
   a_no_match_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_match |-> rsp_start_position == '0)
      else $error("start position set without a match");

   // With the result stage empty the block always takes a transfer.
   a_ready_when_empty: assert property (@(posedge clock)
      !reset && !rsp_valid |-> req_ready)
      else $error("input stalled with empty result stage");

   // No result appears right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind shift_and_exact_matcher sam_checker u_sam_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_match          (rsp_match),
   .rsp_start_position (rsp_start_position)
);
`default_nettype wire

/* test/tb_shift_and_exact_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shift-and exact matcher testbench
// Fills the pattern store, walks the corner cases of the pattern length and
// the command set, runs a full-length pattern with no idling, and then
// streams random search rounds. Each round loads a short pattern and plants
// copies of it in text drawn mostly from a two-symbol alphabet. A predictor
// in the testbench tracks the store, match vector and text position, and
// every result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_shift_and_exact_matcher;

   localparam logic [sam_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 1450;

   typedef struct packed {
      logic                      hit;
      logic [sam_pkg::POS_W-1:0] start;
   } occurrence_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [sam_pkg::CMD_W-1:0]   req_cmd = '0;
   logic [sam_pkg::INDEX_W-1:0] req_pattern_index = '0;
   logic [sam_pkg::BYTE_W-1:0]  req_byte_value = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic                        rsp_match;
   logic [sam_pkg::POS_W-1:0]   rsp_start_position;
   logic                        csr_write_enable = 1'b0;
   logic [sam_pkg::LEN_W-1:0]   csr_write_data = '0;

   logic [sam_pkg::BYTE_W-1:0]      pattern_bytes [sam_pkg::STORE_DEPTH];
   logic [sam_pkg::MAX_PATTERN-1:0] prefix_hits;
   logic [sam_pkg::POS_W-1:0]       text_index;
   logic [sam_pkg::LEN_W-1:0]       length_setting;
   occurrence_type                  expected_occurrences [$];

   bit steady = 1'b0;
   int items_sent = 0;
   int results_checked = 0;
   int matches_seen = 0;
   int length_writes = 0;
   int mismatches = 0;

   shift_and_exact_matcher DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_pattern_index  (req_pattern_index),
      .req_byte_value     (req_byte_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_match          (rsp_match),
      .rsp_start_position (rsp_start_position),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always #1 clock = ~clock;

   function automatic occurrence_type advance_matcher(
         input logic [sam_pkg::CMD_W-1:0]   cmd,
         input logic [sam_pkg::INDEX_W-1:0] index,
         input logic [sam_pkg::BYTE_W-1:0]  value);
      occurrence_type                  found;
      logic [sam_pkg::MAX_PATTERN-1:0] equal_bits;
      logic [sam_pkg::POS_W-1:0]       current;
      int unsigned                     span;
      found = '0;
      case (cmd)
         sam_pkg::CMD_LOAD: pattern_bytes[index] = value;
         sam_pkg::CMD_TEXT: begin
            current = text_index;
            span = length_setting;
            if (span > sam_pkg::NUM_CELLS) span = sam_pkg::NUM_CELLS;
            equal_bits = '0;
            for (int k = 0; k < sam_pkg::NUM_CELLS; k++)
               equal_bits[k] = (pattern_bytes[k] == value);
            prefix_hits = ((prefix_hits << 1) | 1) & equal_bits;
            if (span != 0 && current >= span - 1 && prefix_hits[span - 1]) begin
               found.hit = 1'b1;
               found.start = current - (span - 1);
            end
            if (text_index != '1) text_index = text_index + 1;
         end
         sam_pkg::CMD_RESTART: begin
            prefix_hits = '0;
            text_index = '0;
         end
         default: ;
      endcase
      return found;
   endfunction

   always @(posedge clock) begin
      occurrence_type want;
      if (reset) begin
         prefix_hits = '0;
         text_index = '0;
         length_setting = sam_pkg::LEN_W'(1);
         expected_occurrences.delete();
      end else begin
         if (csr_write_enable) length_setting = csr_write_data;
         if (req_valid && req_ready)
            expected_occurrences.push_back(advance_matcher(req_cmd, req_pattern_index,
                                                           req_byte_value));
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (rsp_match) matches_seen++;
            if (expected_occurrences.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected result match=%0b start=%0d",
                           rsp_match, rsp_start_position);
            end else begin
               want = expected_occurrences.pop_front();
               if (rsp_match !== want.hit || rsp_start_position !== want.start) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"ERROR: result %0d expected match=%0b start=%0d,",
                               " got match=%0b start=%0d"},
                              results_checked, want.hit, want.start, rsp_match,
                              rsp_start_position);
               end
            end
         end
      end
   end

   always @(posedge clock) rsp_ready <= steady || ($urandom_range(0, 99) >= 34);

   task automatic send_item(input logic [sam_pkg::CMD_W-1:0]   cmd,
                            input logic [sam_pkg::INDEX_W-1:0] index,
                            input logic [sam_pkg::BYTE_W-1:0]  value);
      while (!steady && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_pattern_index <= index;
      req_byte_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_occurrences.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_length(input logic [sam_pkg::LEN_W-1:0] length);
      csr_write_enable <= 1'b1;
      csr_write_data <= length;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      length_writes++;
   endtask

   task automatic test_fill_store();
      for (int i = 0; i < sam_pkg::STORE_DEPTH; i++) send_item(sam_pkg::CMD_LOAD, 8'(i), 8'hA5);
   endtask

   task automatic test_corner_cases();
      send_item(sam_pkg::CMD_TEXT, 8'h00, 8'hA5);
      send_item(sam_pkg::CMD_TEXT, 8'hFF, 8'h00);
      send_item(sam_pkg::CMD_TEXT, 8'h00, 8'hFF);
      send_item(CMD_UNUSED, 8'hFF, 8'hA5);
      send_item(sam_pkg::CMD_TEXT, 8'h5A, 8'hA5);
      send_item(sam_pkg::CMD_LOAD, 8'h00, 8'h00);
      send_item(sam_pkg::CMD_LOAD, 8'hFF, 8'hFF);
      send_item(sam_pkg::CMD_RESTART, 8'h00, 8'h00);
      send_item(sam_pkg::CMD_TEXT, 8'h00, 8'h00);
      send_item(sam_pkg::CMD_TEXT, 8'h00, 8'hA5);
      wait_idle();
      write_length(9'd0);
      send_item(sam_pkg::CMD_TEXT, 8'h00, 8'h00);
      send_item(sam_pkg::CMD_TEXT, 8'h00, 8'hA5);
      wait_idle();
      write_length(9'd2);
      send_item(sam_pkg::CMD_TEXT, 8'h00, 8'h00);
      send_item(sam_pkg::CMD_TEXT, 8'h00, 8'hA5);
      send_item(sam_pkg::CMD_TEXT, 8'h00, 8'hA5);
      wait_idle();
      write_length(9'd300);
      send_item(sam_pkg::CMD_TEXT, 8'h00, 8'hA5);
      send_item(sam_pkg::CMD_TEXT, 8'h00, 8'hA5);
      send_item(sam_pkg::CMD_RESTART, 8'hFF, 8'hFF);
      wait_idle();
   endtask

   task automatic test_full_length_pattern();
      steady = 1'b1;
      write_length(9'd256);
      send_item(sam_pkg::CMD_LOAD, 8'h00, 8'hA5);
      send_item(sam_pkg::CMD_LOAD, 8'hFF, 8'hA5);
      send_item(sam_pkg::CMD_RESTART, 8'h00, 8'h00);
      for (int i = 0; i < 258; i++) send_item(sam_pkg::CMD_TEXT, 8'($urandom), 8'hA5);
      wait_idle();
      write_length(9'd511);
      send_item(sam_pkg::CMD_TEXT, 8'h00, 8'hA5);
      send_item(sam_pkg::CMD_TEXT, 8'h00, 8'h5A);
      send_item(sam_pkg::CMD_TEXT, 8'h00, 8'hA5);
      wait_idle();
      steady = 1'b0;
   endtask

   task automatic test_random_search();
      logic [sam_pkg::LEN_W-1:0]  length;
      logic [sam_pkg::BYTE_W-1:0] symbols [2];
      logic [sam_pkg::BYTE_W-1:0] pattern [40];
      logic [sam_pkg::BYTE_W-1:0] text_byte;
      int unsigned                pattern_size, text_size, copy_at, pick;
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) length = '0;
         else if (pick < 6) length = 9'($urandom_range(257, 511));
         else if (pick < 16) length = 9'($urandom_range(9, 40));
         else length = 9'($urandom_range(1, 8));
         wait_idle();
         write_length(length);
         symbols[0] = 8'($urandom);
         symbols[1] = 8'($urandom);
         pattern_size = (length == 0 || length > 40) ? $urandom_range(1, 8) : length;
         for (int i = 0; i < pattern_size; i++) begin
            pattern[i] = symbols[$urandom_range(0, 1)];
            send_item(sam_pkg::CMD_LOAD, 8'(i), pattern[i]);
         end
         if ($urandom_range(0, 9) != 0)
            send_item(sam_pkg::CMD_RESTART, 8'($urandom), 8'($urandom));
         text_size = $urandom_range(12, 48);
         copy_at = pattern_size;
         for (int j = 0; j < text_size; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) send_item(sam_pkg::CMD_LOAD, 8'($urandom), 8'($urandom));
            else if (pick < 4) send_item(CMD_UNUSED, 8'($urandom), 8'($urandom));
            else if (pick < 5) send_item(sam_pkg::CMD_RESTART, 8'($urandom), 8'($urandom));
            else begin
               if (copy_at >= pattern_size && $urandom_range(0, 2) == 0) copy_at = 0;
               if (copy_at < pattern_size) begin
                  text_byte = pattern[copy_at];
                  copy_at++;
               end else if ($urandom_range(0, 9) != 0) begin
                  text_byte = symbols[$urandom_range(0, 1)];
               end else begin
                  text_byte = 8'($urandom);
               end
               send_item(sam_pkg::CMD_TEXT, 8'($urandom), text_byte);
            end
         end
      end
      wait_idle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_store();
      test_corner_cases();
      test_full_length_pattern();
      test_random_search();
      repeat (8) @(posedge clock);
      $display("Sent %0d transfers over %0d length settings; checked %0d results, %0d matches.",
               items_sent, length_writes, results_checked, matches_seen);
      if (mismatches == 0 && expected_occurrences.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
